// ===== sv/lwfs_pkg.sv =====
package lwfs_pkg;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Input modes
  localparam logic [1:0] MODE_STEP  = 2'd0;
  localparam logic [1:0] MODE_FILL  = 2'd1;
  localparam logic [1:0] MODE_PIXEL = 2'd2;

  // Configuration register indexes
  localparam logic [0:0] CFG_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_HEIGHT = 1'b1;

  localparam logic [15:0] WIDTH_RST  = 16'd240;
  localparam logic [15:0] HEIGHT_RST = 16'd320;

  // Panel commands
  localparam logic [7:0] CMD_CASET = 8'h2A;
  localparam logic [7:0] CMD_PASET = 8'h2B;
  localparam logic [7:0] CMD_RAMWR = 8'h2C;

  // Header byte positions
  localparam logic [3:0] HDR_CASET = 4'd0;
  localparam logic [3:0] HDR_XS_HI = 4'd1;
  localparam logic [3:0] HDR_XS_LO = 4'd2;
  localparam logic [3:0] HDR_XE_HI = 4'd3;
  localparam logic [3:0] HDR_XE_LO = 4'd4;
  localparam logic [3:0] HDR_PASET = 4'd5;
  localparam logic [3:0] HDR_YS_HI = 4'd6;
  localparam logic [3:0] HDR_YS_LO = 4'd7;
  localparam logic [3:0] HDR_YE_HI = 4'd8;
  localparam logic [3:0] HDR_YE_LO = 4'd9;
  localparam logic [3:0] HDR_RAMWR = 4'd10;
  localparam logic [3:0] HDR_LEN   = 4'd11;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] rect_w;
    logic [15:0] rect_h;
    logic [15:0] color;
  } lwfs_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } lwfs_out_t;

  typedef enum logic [1:0] {
    ENT_LOAD,
    ENT_HDR,
    ENT_COL_HI,
    ENT_COL_LO
  } ent_kind_t;

  // One queued work entry: either a window load or one byte to emit
  typedef struct packed {
    ent_kind_t   kind;
    logic [3:0]  hdr_idx;
    logic        last;
    logic [15:0] xs;
    logic [15:0] xe;
    logic [15:0] ys;
    logic [15:0] ye;
    logic [15:0] color;
  } ent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== sv/lwfs_front.sv =====
module lwfs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_take,
  input  lwfs_pkg::lwfs_in_t in_item,
  output logic              q_push,
  output lwfs_pkg::ent_t    q_ent,
  output logic              busy
);
  import lwfs_pkg::*;

  logic [15:0] width_r, height_r;
  logic        busy_r, busy_nxt;
  logic [3:0]  hdr_r, hdr_nxt;
  logic        lowb_r, lowb_nxt;
  logic [31:0] pix_r, pix_nxt;
  logic        mul_pend_r, mul_pend_nxt;
  logic [15:0] wc_r, wc_nxt, hc_r, hc_nxt;

  logic        is_start, start, step, over_x, over_y;
  logic [16:0] sum_x, sum_y;
  logic [15:0] xe, ye;
  logic [31:0] prod;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify the incoming transaction
  always_comb begin
    is_start = (in_item.mode == MODE_FILL) || (in_item.mode == MODE_PIXEL);
    start    = in_take && is_start && !busy_r &&
               (in_item.pos_x < width_r) && (in_item.pos_y < height_r);
    step     = in_take && (in_item.mode == MODE_STEP) && busy_r;
  end

  // Clip a fill against the panel edge; window end = start + size - 1 (16-bit wrap), or start + 1 for a pixel
  always_comb begin
    sum_x  = {1'b0, in_item.pos_x} + {1'b0, in_item.rect_w};
    sum_y  = {1'b0, in_item.pos_y} + {1'b0, in_item.rect_h};
    over_x = sum_x > {1'b0, width_r};
    over_y = sum_y > {1'b0, height_r};
    if (in_item.mode == MODE_PIXEL) begin
      xe     = in_item.pos_x + 16'd1;
      ye     = in_item.pos_y + 16'd1;
      wc_nxt = 16'd1;
      hc_nxt = 16'd1;
    end else begin
      xe     = over_x ? width_r - 16'd1 : in_item.pos_x + in_item.rect_w - 16'd1;
      ye     = over_y ? height_r - 16'd1 : in_item.pos_y + in_item.rect_h - 16'd1;
      wc_nxt = over_x ? width_r - in_item.pos_x : in_item.rect_w;
      hc_nxt = over_y ? height_r - in_item.pos_y : in_item.rect_h;
    end
  end

  // Pixel count, taken in the cycle after the start
  assign prod = {16'd0, wc_r} * {16'd0, hc_r};

  // Sequencer next state and queue entry
  always_comb begin
    busy_nxt     = busy_r;
    hdr_nxt      = hdr_r;
    lowb_nxt     = lowb_r;
    pix_nxt      = mul_pend_r ? prod : pix_r;
    mul_pend_nxt = 1'b0;
    q_push       = start || step;
    q_ent        = '0;
    q_ent.kind   = ENT_LOAD;
    if (start) begin
      busy_nxt     = 1'b1;
      hdr_nxt      = '0;
      lowb_nxt     = 1'b0;
      mul_pend_nxt = 1'b1;
      q_ent.xs     = in_item.pos_x;
      q_ent.xe     = xe;
      q_ent.ys     = in_item.pos_y;
      q_ent.ye     = ye;
      q_ent.color  = in_item.color;
    end else if (step) begin
      if (hdr_r < HDR_LEN) begin
        q_ent.kind    = ENT_HDR;
        q_ent.hdr_idx = hdr_r;
        hdr_nxt       = hdr_r + 4'd1;
        if (hdr_r == HDR_RAMWR && pix_r == '0) begin
          q_ent.last = 1'b1;
          busy_nxt   = 1'b0;
        end
      end else if (!lowb_r) begin
        q_ent.kind = ENT_COL_HI;
        lowb_nxt   = 1'b1;
      end else begin
        q_ent.kind = ENT_COL_LO;
        lowb_nxt   = 1'b0;
        pix_nxt    = pix_r - 32'd1;
        if (pix_r == 32'd1) begin
          q_ent.last = 1'b1;
          busy_nxt   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      hdr_r      <= '0;
      lowb_r     <= 1'b0;
      pix_r      <= '0;
      mul_pend_r <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      hdr_r      <= hdr_nxt;
      lowb_r     <= lowb_nxt;
      pix_r      <= pix_nxt;
      mul_pend_r <= mul_pend_nxt;
    end
  end

  // Clipped size, held for the count multiply
  always_ff @(posedge clk) begin
    if (start) begin
      wc_r <= wc_nxt;
      hc_r <= hc_nxt;
    end
  end

  assign busy = busy_r;

endmodule

// ===== sv/lwfs_queue.sv =====
module lwfs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lwfs_pkg::ent_t    wr_ent,
  input  logic              pop,
  output lwfs_pkg::ent_t    rd_ent,
  output lwfs_pkg::q_stat_t stat
);
  import lwfs_pkg::*;

  ent_t           ent_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= wr_ent;
    end
  end

  // Pointers and fill count
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QAW'(1);
      if (pop)  rp_r <= rp_r + QAW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  assign rd_ent     = ent_r[rp_r];
  assign stat.full  = (cnt_r == QCW'(QDEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

// ===== sv/lwfs_back.sv =====
module lwfs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  lwfs_pkg::q_stat_t q_stat,
  input  lwfs_pkg::ent_t    q_head,
  output logic              q_pop,
  input  logic              out_pop,
  output logic              out_empty,
  output lwfs_pkg::lwfs_out_t out_data
);
  import lwfs_pkg::*;

  logic [15:0] xs_r, xe_r, ys_r, ye_r, color_r;
  logic        out_vld_r, out_vld_nxt;
  lwfs_out_t   out_r, out_nxt;
  logic        can_take, is_load;

  // Header byte for a given position of the address-window sequence
  function automatic logic [8:0] hdr_byte(input logic [3:0] idx, input logic [15:0] xs,
                                          input logic [15:0] xe, input logic [15:0] ys,
                                          input logic [15:0] ye);
    logic [8:0] r;
    case (idx)
      HDR_CASET: r = {1'b0, CMD_CASET};
      HDR_XS_HI: r = {1'b1, xs[15:8]};
      HDR_XS_LO: r = {1'b1, xs[7:0]};
      HDR_XE_HI: r = {1'b1, xe[15:8]};
      HDR_XE_LO: r = {1'b1, xe[7:0]};
      HDR_PASET: r = {1'b0, CMD_PASET};
      HDR_YS_HI: r = {1'b1, ys[15:8]};
      HDR_YS_LO: r = {1'b1, ys[7:0]};
      HDR_YE_HI: r = {1'b1, ye[15:8]};
      HDR_YE_LO: r = {1'b1, ye[7:0]};
      default:   r = {1'b0, CMD_RAMWR};
    endcase
    return r;
  endfunction

  // Window loads always drain; byte entries wait for room in the output stage
  always_comb begin
    can_take = !out_vld_r || out_pop;
    is_load  = (q_head.kind == ENT_LOAD);
    q_pop    = !q_stat.empty && (is_load || can_take);
  end

  // Format the output byte
  always_comb begin
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r && !out_pop;
    if (q_pop && !is_load) begin
      out_vld_nxt  = 1'b1;
      out_nxt.last = q_head.last;
      case (q_head.kind)
        ENT_HDR: begin
          {out_nxt.is_data, out_nxt.out_byte} =
            hdr_byte(q_head.hdr_idx, xs_r, xe_r, ys_r, ye_r);
        end
        ENT_COL_HI: begin
          out_nxt.is_data  = 1'b1;
          out_nxt.out_byte = color_r[15:8];
        end
        default: begin
          out_nxt.is_data  = 1'b1;
          out_nxt.out_byte = color_r[7:0];
        end
      endcase
    end
  end

  // Latched window and color
  always_ff @(posedge clk) begin
    if (q_pop && is_load) begin
      xs_r    <= q_head.xs;
      xe_r    <= q_head.xe;
      ys_r    <= q_head.ys;
      ye_r    <= q_head.ye;
      color_r <= q_head.color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_empty = !out_vld_r;
  assign out_data  = out_r;

endmodule

// ===== sv/lcd_window_fill_byte_sequencer_top.sv =====
// LCD address-window fill sequencer. Write a fill (mode 1) or pixel draw (mode 2) request,
// then push one step transaction (mode 0) per byte wanted; each step yields one byte
// (0x2A + X window, 0x2B + Y window, 0x2C, then the color high/low per pixel), the final
// one flagged last. Starts and idle steps produce nothing. One transaction is accepted per
// clock while in_full is low; in_full rises only when the 4-entry work queue between the
// classifying front end and the byte formatter is full, which happens only while the
// result side is not popped. With the queue drained, a step's byte passes the queue entry
// and the output register before it reaches the result ports. The pixel count (clipped
// width times height) is formed by a multiplier in the cycle after the start and is needed
// only at the end of the 11-byte header. Panel size registers reset to 240 x 320 and are
// to be written by the user only while no operation is under way; the block does not check.
module lcd_window_fill_byte_sequencer_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_push,
  output logic                in_full,
  input  lwfs_pkg::lwfs_in_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output lwfs_pkg::lwfs_out_t out_data
);
  import lwfs_pkg::*;

  logic      q_push, q_pop, f_busy, in_take;
  ent_t      q_wr_ent, q_head;
  q_stat_t   qs;

  assign in_full = qs.full;
  assign in_take = in_push && !in_full;

  lwfs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_take   (in_take),
    .in_item   (in_data),
    .q_push    (q_push),
    .q_ent     (q_wr_ent),
    .busy      (f_busy)
  );

  lwfs_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_ent (q_wr_ent),
    .pop    (q_pop),
    .rd_ent (q_head),
    .stat   (qs)
  );

  lwfs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (qs),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

  // Front never writes into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !qs.full) else $error("queue push while full");

  // Back never reads an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !qs.empty) else $error("queue pop while empty");

  // An operation only finishes on an accepted step transaction
  a_busy_end_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(f_busy) && $past(rst_n)) |->
      $past(in_push && !in_full && in_data.mode == MODE_STEP))
    else $error("operation ended without a step");

endmodule

// ===== sim/lcd_window_fill_byte_sequencer_top_tb.sv =====
module lcd_window_fill_byte_sequencer_top_tb;
  import lwfs_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS = 45;
  localparam int MAX_FILL_PIXELS = 300;

  // One row of the directed table; want is only used when typed is set
  typedef struct packed {
    lwfs_in_t  item;
    logic      typed;
    lwfs_out_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_push;
  logic        in_full;
  lwfs_in_t    in_data;
  logic        out_empty;
  logic        out_pop = 1'b0;
  lwfs_out_t   out_data;

  lcd_window_fill_byte_sequencer_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  // Shadow copy of the sequencer state and panel size
  logic [15:0] pan_w, pan_h;
  logic        seq_busy;
  logic [3:0]  hdr_pos;
  logic [15:0] win_xs, win_xe, win_ys, win_ye, px_color;
  logic [31:0] px_left;
  logic        lo_next;

  lwfs_out_t   byte_q[$];
  int          live_items;
  int          err_count = 0;
  int          cycles = 0;
  int          burst_left;
  bit          gaps_on;
  int          pop_left = 0;
  int          pop_style = 0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic lwfs_in_t make_req(input logic [1:0] m, input logic [15:0] x, y, w, h, c);
    lwfs_in_t r;
    r.mode   = m;
    r.pos_x  = x;
    r.pos_y  = y;
    r.rect_w = w;
    r.rect_h = h;
    r.color  = c;
    return r;
  endfunction

  function automatic dir_row_t row(input lwfs_in_t it, input logic typed, input logic [7:0] b,
                                   input logic d, input logic l);
    dir_row_t r;
    r.item          = it;
    r.typed         = typed;
    r.want.out_byte = b;
    r.want.is_data  = d;
    r.want.last     = l;
    return r;
  endfunction

  // Size clipped to the panel edge
  function automatic logic [31:0] clip_size(input logic [15:0] pos, size, lim);
    logic [31:0] span;
    span = {16'd0, pos} + {16'd0, size};
    return (span > {16'd0, lim}) ? {16'd0, lim} - {16'd0, pos} : {16'd0, size};
  endfunction

  // Advance the shadow sequencer by one transaction; returns 1 when a byte comes out
  function automatic bit seq_step(input lwfs_in_t it, output lwfs_out_t b);
    logic [31:0] cw, ch;
    b = '0;
    if (it.mode == MODE_FILL || it.mode == MODE_PIXEL) begin
      if (!seq_busy && it.pos_x < pan_w && it.pos_y < pan_h) begin
        win_xs   = it.pos_x;
        win_ys   = it.pos_y;
        px_color = it.color;
        if (it.mode == MODE_FILL) begin
          cw      = clip_size(it.pos_x, it.rect_w, pan_w);
          ch      = clip_size(it.pos_y, it.rect_h, pan_h);
          // window end wraps to 16 bits for a zero size
          win_xe  = 16'({16'd0, it.pos_x} + cw - 32'd1);
          win_ye  = 16'({16'd0, it.pos_y} + ch - 32'd1);
          px_left = cw * ch;
        end else begin
          win_xe  = it.pos_x + 16'd1;
          win_ye  = it.pos_y + 16'd1;
          px_left = 32'd1;
        end
        hdr_pos  = '0;
        lo_next  = 1'b0;
        seq_busy = 1'b1;
        live_items++;
      end
      return 1'b0;
    end
    if (it.mode != MODE_STEP || !seq_busy) return 1'b0;
    live_items++;
    b.is_data = 1'b1;
    if (hdr_pos < HDR_LEN) begin
      case (hdr_pos)
        HDR_CASET: begin
          b.out_byte = CMD_CASET;
          b.is_data  = 1'b0;
        end
        HDR_XS_HI: b.out_byte = win_xs[15:8];
        HDR_XS_LO: b.out_byte = win_xs[7:0];
        HDR_XE_HI: b.out_byte = win_xe[15:8];
        HDR_XE_LO: b.out_byte = win_xe[7:0];
        HDR_PASET: begin
          b.out_byte = CMD_PASET;
          b.is_data  = 1'b0;
        end
        HDR_YS_HI: b.out_byte = win_ys[15:8];
        HDR_YS_LO: b.out_byte = win_ys[7:0];
        HDR_YE_HI: b.out_byte = win_ye[15:8];
        HDR_YE_LO: b.out_byte = win_ye[7:0];
        default: begin
          b.out_byte = CMD_RAMWR;
          b.is_data  = 1'b0;
        end
      endcase
      hdr_pos = hdr_pos + 4'd1;
      if (hdr_pos == HDR_LEN && px_left == 32'd0) begin
        b.last   = 1'b1;
        seq_busy = 1'b0;
      end
    end else if (!lo_next) begin
      b.out_byte = px_color[15:8];
      lo_next    = 1'b1;
    end else begin
      b.out_byte = px_color[7:0];
      lo_next    = 1'b0;
      if (px_left != 32'd0) px_left = px_left - 32'd1;
      if (px_left == 32'd0) begin
        b.last   = 1'b1;
        seq_busy = 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic report(input string msg);
    err_count++;
    if (err_count <= 40) $display("[cycle %0d] mismatch: %s", cycles, msg);
  endtask

  // Send one transaction in bursts with random gaps if gaps_on, then update the shadow model
  task automatic send_req(input lwfs_in_t it, input bit typed, input lwfs_out_t want);
    lwfs_out_t b;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        in_push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (seq_step(it, b)) byte_q.push_back(typed ? want : b);
  endtask

  task automatic send_step();
    send_req(make_req(MODE_STEP, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom)), 1'b0, '0);
  endtask

  // Idle steps, unused mode, starts outside or while busy (all ignored), or a step while busy
  task automatic send_noise();
    lwfs_in_t it;
    it = make_req(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
    if ((it.mode == MODE_FILL || it.mode == MODE_PIXEL) && !seq_busy) begin
      if ($urandom_range(0, 1) == 0) it.pos_x = 16'($urandom_range(pan_w, 65535));
      else it.pos_y = 16'($urandom_range(pan_h, 65535));
    end
    send_req(it, 1'b0, '0);
  endtask

  function automatic logic [15:0] pick_pos(input logic [15:0] lim);
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return lim - 16'd1 - 16'($urandom_range(0, (lim > 16'd4) ? 3 : lim - 1));
      default: return 16'($urandom_range(0, lim - 1));
    endcase
  endfunction

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'($urandom);
      default: return 16'($urandom_range(1, 6));
    endcase
  endfunction

  // A well-formed operation: one start, then steps until the last byte, with noise mixed in
  task automatic run_op();
    logic [15:0] x, y, w, h;
    x = pick_pos(pan_w);
    y = pick_pos(pan_h);
    if ($urandom_range(0, 9) < 7) begin
      w = pick_size();
      h = pick_size();
      if (clip_size(x, w, pan_w) * clip_size(y, h, pan_h) > MAX_FILL_PIXELS) begin
        w = 16'($urandom_range(0, 8));
        h = 16'($urandom_range(0, 8));
      end
      send_req(make_req(MODE_FILL, x, y, w, h, 16'($urandom)), 1'b0, '0);
    end else begin
      send_req(make_req(MODE_PIXEL, x, y, 16'($urandom), 16'($urandom), 16'($urandom)),
               1'b0, '0);
    end
    while (seq_busy) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_step();
    end
  endtask

  // Finish any operation, then hold off until all bytes are out and the pipe is quiet
  task automatic settle();
    while (seq_busy) send_step();
    in_push <= 1'b0;
    while (byte_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_panel(input logic [15:0] w, h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    pan_w  = w;
    pan_h  = h;
  endtask

  // Result side: check each accepted byte, then pick the next pop value
  always @(posedge clk) begin : result_side
    lwfs_out_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (byte_q.size() == 0) begin
          report($sformatf("byte %02h arrived with nothing pending", out_data.out_byte));
        end else begin
          want = byte_q.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report($sformatf("out_byte %02h, expected %02h", out_data.out_byte, want.out_byte));
          if (out_data.is_data !== want.is_data)
            report($sformatf("is_data %b, expected %b", out_data.is_data, want.is_data));
          if (out_data.last !== want.last)
            report($sformatf("last %b, expected %b", out_data.last, want.last));
        end
      end
      if (pop_left == 0) begin
        pop_style = $urandom_range(0, 3);
        pop_left  = $urandom_range(8, 60);
      end
      pop_left--;
      case (pop_style)
        0: out_pop <= 1'b1;
        1: out_pop <= 1'($urandom);
        2: out_pop <= ($urandom_range(0, 3) != 0);
        default: out_pop <= (pop_left < 4);
      endcase
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t    tab[$];
    logic [15:0] pw, ph;

    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_WIDTH;
    cfg_data  <= '0;
    in_push   <= 1'b0;
    in_data   <= '0;
    pan_w      = WIDTH_RST;
    pan_h      = HEIGHT_RST;
    seq_busy   = 1'b0;
    hdr_pos    = '0;
    win_xs     = '0;
    win_xe     = '0;
    win_ys     = '0;
    win_ye     = '0;
    px_color   = '0;
    px_left    = '0;
    lo_next    = 1'b0;
    live_items = 0;
    burst_left = 0;
    gaps_on    = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset panel size 240 x 320
    tab.push_back(row(make_req(MODE_STEP, 0, 0, 0, 0, 0), 0, 0, 0, 0));
    tab.push_back(row(make_req(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                      0, 0, 0, 0));
    tab.push_back(row(make_req(MODE_FILL, 16'd240, 0, 1, 1, 16'h1111), 0, 0, 0, 0));
    tab.push_back(row(make_req(MODE_FILL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                      0, 0, 0, 0));
    tab.push_back(row(make_req(MODE_PIXEL, 0, 16'd320, 0, 0, 16'h2222), 0, 0, 0, 0));
    // zero-size fill in the bottom right corner: header only, window ends one below start
    tab.push_back(row(make_req(MODE_FILL, 16'd239, 16'd319, 0, 0, 16'h1234), 0, 0, 0, 0));
    tab.push_back(row(make_req(MODE_STEP, 0, 0, 0, 0, 0), 1, CMD_CASET, 0, 0));
    tab.push_back(row(make_req(MODE_FILL, 0, 0, 1, 1, 16'h5555), 0, 0, 0, 0));
    tab.push_back(row(make_req(MODE_STEP, 0, 0, 0, 0, 0), 1, 8'h00, 1, 0));
    tab.push_back(row(make_req(MODE_STEP, 0, 0, 0, 0, 0), 1, 8'hEF, 1, 0));
    tab.push_back(row(make_req(MODE_STEP, 0, 0, 0, 0, 0), 1, 8'h00, 1, 0));
    tab.push_back(row(make_req(MODE_STEP, 0, 0, 0, 0, 0), 1, 8'hEE, 1, 0));
    tab.push_back(row(make_req(MODE_STEP, 0, 0, 0, 0, 0), 1, CMD_PASET, 0, 0));
    tab.push_back(row(make_req(MODE_STEP, 0, 0, 0, 0, 0), 1, 8'h01, 1, 0));
    tab.push_back(row(make_req(MODE_STEP, 0, 0, 0, 0, 0), 1, 8'h3F, 1, 0));
    tab.push_back(row(make_req(MODE_STEP, 0, 0, 0, 0, 0), 1, 8'h01, 1, 0));
    tab.push_back(row(make_req(MODE_STEP, 0, 0, 0, 0, 0), 1, 8'h3E, 1, 0));
    tab.push_back(row(make_req(MODE_STEP, 0, 0, 0, 0, 0), 1, CMD_RAMWR, 0, 1));
    tab.push_back(row(make_req(MODE_STEP, 0, 0, 0, 0, 0), 0, 0, 0, 0));
    // pixel draw at the last column and row; remaining bytes come from the drain
    tab.push_back(row(make_req(MODE_PIXEL, 16'd239, 16'd319, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                      0, 0, 0, 0));
    tab.push_back(row(make_req(MODE_STEP, 0, 0, 0, 0, 0), 0, 0, 0, 0));
    tab.push_back(row(make_req(MODE_STEP, 0, 0, 0, 0, 0), 0, 0, 0, 0));
    foreach (tab[i]) send_req(tab[i].item, tab[i].typed, tab[i].want);
    settle();

    // Random part over several panel sizes, extremes included
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: {pw, ph} = {16'd1, 16'd1};
        1: {pw, ph} = {16'hFFFF, 16'hFFFF};
        2: {pw, ph} = {16'hFFFF, 16'd1};
        3: {pw, ph} = {16'd1, 16'hFFFF};
        4: {pw, ph} = {16'd16, 16'd9};
        5, 6: {pw, ph} = {16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535))};
        default: {pw, ph} = {WIDTH_RST, HEIGHT_RST};
      endcase
      write_panel(pw, ph);
      gaps_on    = (p % 3 != 1);
      live_items = 0;
      while (live_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else run_op();
      end
      settle();
    end

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lwfs_pkg.sv
sv/lwfs_front.sv
sv/lwfs_queue.sv
sv/lwfs_back.sv
sv/lcd_window_fill_byte_sequencer_top.sv
sim/lcd_window_fill_byte_sequencer_top_tb.sv
